[rtl/ptw_pkg.sv]
// Package for the four-level page-table walker.
// Holds the item structs, the controller/datapath command and status structs,
// and the table index helper. No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int PA_W   = 52;
  localparam int VA_W   = 48;
  localparam int WORD_W = 64;
  localparam int IDX_W  = 9;
  localparam int OFS_W  = 12;
  localparam int LEVELS = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  typedef logic [1:0] lvl_t;
  localparam lvl_t LAST_LEVEL = lvl_t'(LEVELS - 1);

  typedef struct packed {
    logic              req_type;
    logic [PA_W-1:0]   entry_addr;
    logic [WORD_W-1:0] entry_value;
    logic [VA_W-1:0]   virt_addr;
  } ptw_in_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic            fault;
  } ptw_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic write_load;
    logic read_root;
    logic read_next;
    lvl_t level;
    logic out_load;
    logic fault_out;
  } ptw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic present;
    logic out_free;
  } ptw_sts_t;

  // Nine-bit table index of a virtual address for one walk level.
  function automatic logic [IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va, input lvl_t lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/four_level_page_table_walk_top.sv]
// Top level of the four-level page-table walker.
// Joins ptw_ctrl and ptw_dpath; depends on ptw_pkg.
//
//   Port group   Direction  Carries
//   in_*         input      one item: load a memory word or translate an address
//   out_*        output     one result item per translate: phys_addr and fault
//   cfg_*        input      root_table_base write, no wait
//
// A translate issues the first table read in its intake cycle, then checks one entry
// per walk step, issuing the next read on the single memory port until a missing
// entry or the fourth entry ends the walk. A load writes its word at intake; one
// beyond the store is dropped. A result may wait in the output register while the
// next item is taken; a walk that finishes while it is still full holds until it
// drains. After reset the memory is cleared one word a cycle, all 2**(PADDR_BITS-3)
// words (8192 by default), with in_ready low.
`default_nettype none

module four_level_page_table_walk_top import ptw_pkg::*; #(
  parameter int PADDR_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ptw_in_t         in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ptw_out_t             out_data,
  input  wire logic            cfg_we,
  input  wire logic [PA_W-1:0] cfg_wdata
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_data.req_type),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ptw_dpath #(
    .PADDR_BITS(PADDR_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[rtl/ptw_dpath.sv]
// Datapath of the page-table walker: word memory, root register, walk
// address adder and the result register. Depends on ptw_pkg.
`default_nettype none

module ptw_dpath import ptw_pkg::*; #(
  parameter int PADDR_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptw_in_t             in_data,
  input  wire logic                cfg_we,
  input  wire logic [PA_W-1:0]     cfg_wdata,
  input  wire ptw_cmd_t            cmd,
  output ptw_sts_t                 sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ptw_out_t                 out_data
);

  localparam int WIDX_W    = PADDR_BITS - 3;
  localparam int MEM_WORDS = 2 ** WIDX_W;

  logic [WORD_W-1:0] mem [MEM_WORDS];

  logic [PA_W-1:0]   root_r;
  logic [VA_W-1:0]   vaddr_r;
  logic [WIDX_W-1:0] clr_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              oob_r;
  logic              out_valid_r;
  ptw_out_t          out_data_r;

  logic [PA_W-1:0]   rd_base;
  logic [IDX_W-1:0]  rd_idx;
  logic [PA_W:0]     rd_sum;
  logic              rd_oob;
  logic [PA_W:0]     wr_ext;
  logic              wr_oob;
  logic              mem_we;
  logic              mem_re;
  logic [WIDX_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] entry;
  logic [PA_W-1:0]   result;

  // A read beyond the store returns zero, so the entry is masked here.
  assign entry = oob_r ? '0 : rd_data_r;

  always_comb begin
    rd_base = cmd.read_root ? root_r : {entry[PA_W-1:OFS_W], {OFS_W{1'b0}}};
    rd_idx  = cmd.read_root ? lvl_index(in_data.virt_addr, lvl_t'(0))
                            : lvl_index(vaddr_r, cmd.level);
    rd_sum  = {1'b0, rd_base} + {{(PA_W + 1 - IDX_W - 3){1'b0}}, rd_idx, 3'b000};
    rd_oob  = |rd_sum[PA_W:PADDR_BITS];
    wr_ext  = {1'b0, in_data.entry_addr};
    wr_oob  = |wr_ext[PA_W:PADDR_BITS];
    mem_we  = cmd.clear_step | (cmd.write_load & ~wr_oob);
    mem_re  = cmd.read_root | cmd.read_next;
    mem_waddr = cmd.clear_step ? clr_r : in_data.entry_addr[PADDR_BITS-1:3];
    mem_wdata = cmd.clear_step ? '0 : in_data.entry_value;
    result  = {entry[PA_W-1:OFS_W], vaddr_r[OFS_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_sum[PADDR_BITS-1:3]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      oob_r <= rd_oob;
    end
    if (cmd.read_root) begin
      vaddr_r <= in_data.virt_addr;
    end
    if (cmd.out_load) begin
      if (cmd.fault_out || result == '0) begin
        out_data_r <= '{phys_addr: '0, fault: 1'b1};
      end else begin
        out_data_r <= '{phys_addr: result, fault: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
      if (cmd.clear_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clear_last = &clr_r;
  assign sts.present    = entry[0];
  assign sts.out_free   = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/ptw_ctrl.sv]
// Controller of the page-table walker: clearing pass, item intake and the
// four-level walk sequence. Depends on ptw_pkg.
`default_nettype none

module ptw_ctrl import ptw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_req_type,
  output logic          in_ready,
  input  wire ptw_sts_t sts,
  output ptw_cmd_t      cmd
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} state_t;

  state_t state_r;
  lvl_t   lvl_r;
  logic   finish;

  // The walk ends on a missing entry or after the last level's entry.
  assign finish   = ~sts.present | (lvl_r == LAST_LEVEL);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.write_load = 1'b1;
          end else begin
            cmd.read_root = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (finish) begin
          cmd.out_load  = sts.out_free;
          cmd.fault_out = ~sts.present;
        end else begin
          cmd.read_next = 1'b1;
          cmd.level     = lvl_r + 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      lvl_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_req_type == REQ_XLATE) begin
            state_r <= ST_WALK;
            lvl_r   <= '0;
          end
        end
        ST_WALK: begin
          if (finish) begin
            if (sts.out_free) begin
              state_r <= ST_IDLE;
            end
          end else begin
            lvl_r <= lvl_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ptw_checker.sv]
// Port-level checks for the page-table walker, bound to its top level.
// Depends on ptw_pkg.
`default_nettype none

module ptw_checker import ptw_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire ptw_in_t         in_data,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire ptw_out_t        out_data
);

  // A stalled result item must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A faulted result always reports address zero.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.phys_addr == '0)
    else $error("faulted result with nonzero address");

  // A good result never carries address zero.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fault |-> out_data.phys_addr != '0)
    else $error("zero address reported without fault");

  // A translate keeps the intake closed while the walk runs.
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_XLATE |=> !in_ready)
    else $error("item taken during a walk");

  // Reset closes the intake (memory clearing follows) and empties the output.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("reset did not close intake and output");

endmodule

bind four_level_page_table_walk_top ptw_checker u_ptw_checker (.*);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the four-level page-table walker top level.
// Builds page tables through load items, then checks every translation against a
// shadow copy of the block's word store. Depends on ptw_pkg and the RTL top.
module tb_top import ptw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PADDR_BITS = 16;
  localparam logic [63:0] MEM_BYTES  = 64'd1 << PADDR_BITS;
  localparam int          MEM_WORDS  = 1 << (PADDR_BITS - 3);
  localparam int          SETTLE     = 16;
  localparam int          LONG_HOLD  = 300;
  localparam logic [51:0] ROOT_MAX   = 52'hF_FFFF_FFFF_FFFF;

  typedef enum int {BREAK_NONE, BREAK_ABSENT, BREAK_WILD} walk_break_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  ptw_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ptw_out_t        out_data;
  logic            cfg_we    = 1'b0;
  logic [PA_W-1:0] cfg_wdata = '0;

  four_level_page_table_walk_top #(.PADDR_BITS(PADDR_BITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow of the block's state.
  logic [63:0] shadow_mem [MEM_WORDS];
  logic [51:0] root_base = '0;

  ptw_in_t     pending_items [$];
  ptw_out_t    expected_xlate [$];
  logic [47:0] seen_va [$];

  int queued     = 0;
  int fail_count = 0;
  int n_loads    = 0;
  int n_xlates   = 0;
  int n_faults   = 0;
  int n_roots    = 0;
  int hold_req   = 0;
  int hold_ack   = 0;

  logic     in_fire  = 1'b0;
  int       in_gap   = 0;
  int       in_burst = 0;
  int       out_hold = 0;
  int       out_burst = 0;
  ptw_out_t want;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Four-level walk over the shadow store, from the current root.
  function automatic ptw_out_t walk_predict(input logic [47:0] va);
    logic [63:0] base;
    logic [63:0] byte_addr;
    logic [63:0] entry;
    ptw_out_t    res;
    base = {12'd0, root_base};
    for (int lvl = 0; lvl < 4; lvl++) begin
      byte_addr = base + {52'd0, va[(39 - 9 * lvl) +: 9], 3'b000};
      entry = (byte_addr < MEM_BYTES) ? shadow_mem[byte_addr[PADDR_BITS-1:3]] : 64'd0;
      if (!entry[0]) begin
        res.phys_addr = '0;
        res.fault     = 1'b1;
        return res;
      end
      base = {12'd0, entry[51:12], 12'd0};
    end
    res.phys_addr = base[51:0] + {40'd0, va[11:0]};
    res.fault     = (res.phys_addr == '0);
    return res;
  endfunction

  task automatic push_load(input logic [51:0] addr, input logic [63:0] value);
    ptw_in_t it;
    it.req_type    = REQ_LOAD;
    it.entry_addr  = addr;
    it.entry_value = value;
    it.virt_addr   = 48'(rand64());
    pending_items = {pending_items, it};
    queued++;
  endtask

  task automatic push_xlate(input logic [47:0] va);
    ptw_in_t it;
    it.req_type    = REQ_XLATE;
    it.entry_addr  = 52'(rand64());
    it.entry_value = rand64();
    it.virt_addr   = va;
    pending_items = {pending_items, it};
    queued++;
  endtask

  // Loads the four entries that the walk of va will read, then translates va.
  // A break spoils one level: either its present bit is clear or it points
  // outside the store.
  task automatic push_walk(input logic [51:0] root, input logic [47:0] va,
                           input walk_break_e brk, input int brk_lvl,
                           input logic [39:0] last_pfn);
    logic [63:0] base;
    logic [63:0] addr;
    logic [63:0] entry;
    logic [39:0] pfn;
    base = {12'd0, root};
    for (int lvl = 0; lvl < 4; lvl++) begin
      addr = base + {52'd0, va[(39 - 9 * lvl) +: 9], 3'b000};
      pfn = (lvl == 3) ? last_pfn : 40'($urandom_range(0, 15));
      if (brk == BREAK_WILD && lvl == brk_lvl) pfn = 40'($urandom_range(16, 32'hFFFF_FFFF));
      entry = {12'($urandom), pfn, 11'($urandom), 1'b1};
      if (brk == BREAK_ABSENT && lvl == brk_lvl) entry[0] = 1'b0;
      // The low three address bits only pick a byte within the word.
      push_load(addr[51:0] | {49'd0, 3'($urandom)}, entry);
      base = {12'd0, pfn, 12'd0};
    end
    push_xlate(va);
    seen_va = {seen_va, va};
  endtask

  task automatic fill_phase(input logic [51:0] root, input int target);
    int          start;
    int          r;
    logic [47:0] va;
    logic [39:0] pfn;
    start = queued;
    while (queued - start < target) begin
      r  = $urandom_range(0, 99);
      va = 48'(rand64());
      if (r < 60) begin
        r = $urandom_range(0, 9);
        pfn = (r == 0) ? 40'd0 : (r == 1) ? '1 : 40'(rand64());
        push_walk(root, va, BREAK_NONE, 0, pfn);
        repeat ($urandom_range(0, 2)) push_xlate({va[47:12], 12'($urandom)});
      end else if (r < 70) begin
        push_walk(root, va, BREAK_ABSENT, $urandom_range(0, 3), 40'(rand64()));
      end else if (r < 75) begin
        push_walk(root, va, BREAK_WILD, $urandom_range(0, 2), 40'(rand64()));
      end else if (r < 85 && seen_va.size() != 0) begin
        push_xlate(seen_va[$urandom_range(0, seen_va.size() - 1)]);
      end else if (r < 92) begin
        if ($urandom_range(0, 1) == 0) push_load(52'(rand64()), rand64());
        else push_load(52'($urandom_range(0, 32'hFFFF)), rand64());
      end else begin
        push_xlate(va);
      end
    end
  endtask

  task automatic write_root(input logic [51:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    root_base = value;
    n_roots++;
  endtask

  // A load leaves no result behind, so give the block time to finish it.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_xlate.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (in_burst > 0) begin
          in_burst <= in_burst - 1;
          in_gap   <= 0;
        end else if ($urandom_range(0, 49) == 0) begin
          in_burst <= 40;
          in_gap   <= 0;
        end else begin
          in_gap <= ($urandom_range(0, 99) < 55) ? 0 : rand_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side ready, with an occasional long hold-off to back up the block.
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      out_hold  <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (out_burst > 0) begin
      out_burst <= out_burst - 1;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_burst <= 40;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 55) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      out_hold  <= rand_gap() - 1;
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      if (in_data.req_type == REQ_XLATE) begin
        expected_xlate = {expected_xlate, walk_predict(in_data.virt_addr)};
        n_xlates++;
      end else begin
        if ({12'd0, in_data.entry_addr} < MEM_BYTES)
          shadow_mem[in_data.entry_addr[PADDR_BITS-1:3]] = in_data.entry_value;
        n_loads++;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_xlate.size() == 0) begin
        $error("result item with no translation pending: phys_addr %h fault %b",
               out_data.phys_addr, out_data.fault);
        fail_count++;
      end else begin
        want = expected_xlate.pop_front();
        if (out_data.phys_addr !== want.phys_addr) begin
          $error("phys_addr mismatch: expected %h, actual %h", want.phys_addr,
                 out_data.phys_addr);
          fail_count++;
        end
        if (out_data.fault !== want.fault) begin
          $error("fault mismatch: expected %b, actual %b", want.fault, out_data.fault);
          fail_count++;
        end
        if (out_data.fault === 1'b1) n_faults++;
      end
    end
  end

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    write_root('0);

    // Directed items. The store is empty, so the first walk faults at once.
    push_xlate('0);
    push_load(52'h1_0000, '1);
    push_load(ROOT_MAX, '1);
    // An unaligned load of word 0 that points back at table 0 with base 0; the
    // page-size bit is set but must be ignored.
    push_load(52'h5, 64'hFFF0_0000_0000_0081);
    push_xlate('0);
    push_xlate(48'h0000_0000_0FFF);
    push_xlate('1);
    push_walk('0, {36'(rand64()), 12'hFFF}, BREAK_NONE, 0, '1);
    push_walk('0, 48'(rand64()), BREAK_ABSENT, 3, 40'(rand64()));
    push_walk('0, 48'(rand64()), BREAK_WILD, 1, 40'(rand64()));
    push_walk('0, 48'(rand64()), BREAK_NONE, 0, 40'(rand64()));
    wait_idle();

    write_root(52'($urandom_range(0, 15)) << 12);
    fill_phase(root_base, 220);
    hold_req++;
    wait_idle();

    write_root(ROOT_MAX);
    fill_phase(root_base, 100);
    wait_idle();

    write_root(52'($urandom_range(0, 32'hFFFF)));
    fill_phase(root_base, 220);
    wait_idle();

    write_root('0);
    fill_phase(root_base, 190);
    hold_req++;
    wait_idle();

    write_root(52'(rand64()));
    fill_phase(root_base, 100);
    wait_idle();

    write_root(52'($urandom_range(0, 15)) << 12);
    fill_phase(root_base, 220);
    wait_idle();

    $display("Ran %0d loads and %0d translations (%0d faulted) under %0d root settings,",
             n_loads, n_xlates, n_faults, n_roots);
    $display("including empty, unaligned, out-of-store, zero and maximum-address walks.");
    if (fail_count == 0) begin
      $display("PASS four_level_page_table_walk_top");
    end else begin
      $display("FAIL four_level_page_table_walk_top");
    end
    $finish;
  end

  initial begin
    #800us;
    $display("FAIL four_level_page_table_walk_top");
    $finish;
  end

endmodule

[four_level_page_table_walk_top.f]
rtl/ptw_pkg.sv
rtl/ptw_dpath.sv
rtl/ptw_ctrl.sv
rtl/four_level_page_table_walk_top.sv
rtl/ptw_checker.sv
dv/tb_top.sv
